// ===== hdl/ambrc_pkg.sv =====
`default_nettype none
package ambrc_pkg;

  localparam int MAX_LEVEL_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // fixed field widths of the result transaction
  localparam int LEVEL_W   = 5;
  localparam int OUT_CNT_W = 32;
  localparam int PCT_A_W   = 7;
  localparam int PCT_E_W   = 11;
  localparam int TDATA_W   = 88;

  // width of the report sums, saturating
  localparam int SUM_W = 64;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } hist_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/ambrc_hist.sv =====
`default_nettype none
module ambrc_hist
  import ambrc_pkg::*;
#(
  parameter int DEPTH  = MAX_LEVEL_DEF + 1,
  parameter int DATA_W = COUNT_WIDTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hist_ctl_t         ctl,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] q;
  logic              qv;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      q <= mem[rd_addr];
    end
  end

  // an entry not written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      qv  <= 1'b0;
    end else begin
      if (ctl.rd) begin
        qv <= vld[rd_addr];
      end
      if (ctl.clr) begin
        vld <= '0;
      end else if (ctl.wr) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = qv ? q : '0;

endmodule
`default_nettype wire

// ===== hdl/ambrc_div.sv =====
`default_nettype none
module ambrc_div
  import ambrc_pkg::*;
#(
  parameter int NUM_W = SUM_W + 7,
  parameter int DEN_W = COUNT_WIDTH_DEF,
  parameter int Q_W   = PCT_E_W,
  localparam int CNT_W = $clog2(NUM_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quot,
  output logic                  done
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] sh;
  logic [Q_W-1:0]   q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, sh[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one numerator bit a cycle; only the low quotient bits are kept
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      sh    <= num;
      q     <= '0;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh  <= sh << 1;
      q   <= {q[Q_W-2:0], ge};
    end
  end

  assign quot = q;

endmodule
`default_nettype wire

// ===== hdl/ambrc_parse.sv =====
`default_nettype none
module ambrc_parse
  import ambrc_pkg::*;
#(
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int LVL_W = $clog2(MAX_LEVEL + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   clr,
  input  wire logic                   byte_en,
  input  wire logic [7:0]             byte_in,
  output logic                        inc,
  output logic      [LVL_W-1:0]       inc_bin,
  output logic      [COUNT_WIDTH-1:0] words
);

  localparam int V_W = LVL_W + 4;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_BSL   = 6'b000010,
    PH_SKIP  = 6'b000100,
    PH_PCT   = 6'b001000,
    PH_DIG   = 6'b010000,
    PH_DUMMY = 6'b100000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [LVL_W-1:0]       acc, acc_next;
  logic [COUNT_WIDTH-1:0] words_next;
  logic                   halted, halted_next;
  logic                   is_digit;
  logic [V_W-1:0]         acc_ext;
  logic [V_W-1:0]         v;

  always_comb begin
    is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    acc_ext  = V_W'(acc);
    v        = (acc_ext << 3) + (acc_ext << 1) + V_W'(4'(byte_in - CH_ZERO));
  end

  always_comb begin
    phase_next  = phase;
    acc_next    = acc;
    words_next  = words;
    halted_next = halted;
    inc         = 1'b0;
    inc_bin     = '0;
    if (byte_en && !halted) begin
      unique case (phase)
        PH_IDLE: begin
          if (byte_in == CH_NUL) begin
            halted_next = 1'b1;
          end else if (byte_in == CH_BSLASH) begin
            phase_next = PH_BSL;
          end
        end
        PH_BSL: begin
          if (byte_in == CH_A) begin
            words_next = (&words) ? words : words + COUNT_WIDTH'(1);
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_SKIP: begin
          phase_next = PH_PCT;
        end
        PH_PCT: begin
          if (byte_in == CH_PCT) begin
            acc_next   = '0;
            phase_next = PH_DIG;
          end else begin
            inc        = 1'b1;
            inc_bin    = LVL_W'(1);
            phase_next = PH_IDLE;
          end
        end
        PH_DIG: begin
          if (is_digit) begin
            // clamp keeps any nonzero number nonzero
            acc_next = (v > V_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : LVL_W'(v);
          end else if (acc == '0) begin
            phase_next = PH_DUMMY;
          end else begin
            inc        = 1'b1;
            inc_bin    = acc;
            phase_next = PH_IDLE;
          end
        end
        PH_DUMMY: begin
          if (byte_in == CH_PCT) begin
            // drop the dummy record again
            words_next = (words != '0) ? words - COUNT_WIDTH'(1) : words;
          end else begin
            inc     = 1'b1;
            inc_bin = '0;
          end
          phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      phase  <= PH_IDLE;
      acc    <= '0;
      words  <= '0;
      halted <= 1'b0;
    end else begin
      phase  <= phase_next;
      acc    <= acc_next;
      words  <= words_next;
      halted <= halted_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ambiguity_record_counter.sv =====
`default_nettype none
// Counts word records in a text stream and reports a histogram of their levels.
// Input channel s_axis: one text byte per transaction in tdata[7:0]; a transaction
// with tlast high carries no byte and closes the stream. Bytes are taken one per
// cycle while no report runs; a byte that completes a record updates the histogram
// memory with a read in its accept cycle and the write-back in the next, which
// never meets another update since a record needs several more bytes before the
// next one counts. On end of stream s_axis_tready drops while the report runs: a
// walk over the histogram memory (read, multiply and add per bin), a clamp of the
// sums (analysed count, limit, clamp), and two bit-serial divisions of SUM_W+7
// steps each for the percentages, then one result per bin, levels 0 to MAX_LEVEL,
// each read from the histogram and then loaded. When no word was analysed the
// divisions are skipped.
// Output channel m_axis: one registered transaction per bin; tlast marks the bin
// MAX_LEVEL. A stall on m_axis_tready holds the result and the walk; after the
// last bin is loaded, counts and histogram are cleared and bytes are taken
// again while that result still waits.
// Reset clears the parser, the word count and the histogram (per-bin valid
// flags, no clearing pass) and empties the output register.
module ambiguity_record_counter
  import ambrc_pkg::*;
#(
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,  // text_byte
  input  wire logic               s_axis_tlast,  // end_of_stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // level[4:0], level_count[36:5], word_count[68:37], pct_ambiguous[75:69],
  // pct_excess[86:76], zero[87]
  output logic      [TDATA_W-1:0] m_axis_tdata,
  output logic                    m_axis_tuser,  // ratios_valid
  output logic                    m_axis_tlast   // last_bin
);

  localparam int BINS   = MAX_LEVEL + 1;
  localparam int LVL_W  = $clog2(BINS);
  localparam int PROD_W = COUNT_WIDTH + LVL_W;
  localparam int ACC_W  = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;
  localparam int NUM_W  = SUM_W + 7;

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_SUM_RD  = 13'b0000000000010,
    ST_SUM_MUL = 13'b0000000000100,
    ST_SUM_ADD = 13'b0000000001000,
    ST_AN      = 13'b0000000010000,
    ST_LIM     = 13'b0000000100000,
    ST_CLAMP   = 13'b0000001000000,
    ST_NUM_A   = 13'b0000010000000,
    ST_DIV_A   = 13'b0000100000000,
    ST_NUM_E   = 13'b0001000000000,
    ST_DIV_E   = 13'b0010000000000,
    ST_EMIT_RD = 13'b0100000000000,
    ST_EMIT_LD = 13'b1000000000000
  } state_t;

  state_t                 state, state_next;
  logic                   in_acc, byte_en, eos;
  logic                   inc;
  logic [LVL_W-1:0]       inc_bin;
  logic [COUNT_WIDTH-1:0] words;
  logic                   pend;
  logic [LVL_W-1:0]       pend_bin;
  hist_ctl_t              hctl;
  logic [LVL_W-1:0]       rd_addr;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] wr_data;

  logic [LVL_W-1:0]       k;
  logic                   k_last;
  logic [LVL_W-1:0]       km1;
  logic [COUNT_WIDTH-1:0] h0;
  logic [COUNT_WIDTH-1:0] analyzed;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      lim;
  logic [SUM_W-1:0]       amb_words;
  logic [SUM_W-1:0]       amb_total;
  logic [ACC_W-1:0]       words_sum, total_sum;
  logic [SUM_W-1:0]       words_sat, total_sat;
  logic [NUM_W-1:0]       num;
  logic                   div_start;
  logic                   div_done;
  logic [PCT_E_W-1:0]     quot;
  logic [PCT_A_W-1:0]     pa;
  logic [PCT_E_W-1:0]     pe;
  logic                   rvalid;
  logic                   load, finish;

  logic [LEVEL_W-1:0]     out_level;
  logic [OUT_CNT_W-1:0]   out_count;
  logic [OUT_CNT_W-1:0]   out_words;
  logic [PCT_A_W-1:0]     out_pa;
  logic [PCT_E_W-1:0]     out_pe;
  logic                   out_rv;
  logic                   out_last;

  function automatic logic [NUM_W-1:0] times100(input logic [SUM_W-1:0] x);
    logic [NUM_W-1:0] xe;
    xe = NUM_W'(x);
    return (xe << 6) + (xe << 5) + (xe << 2);
  endfunction

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign byte_en       = in_acc && !s_axis_tlast;
  assign eos           = in_acc && s_axis_tlast;

  ambrc_parse #(
    .MAX_LEVEL  (MAX_LEVEL),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .clr    (finish),
    .byte_en(byte_en),
    .byte_in(s_axis_tdata),
    .inc    (inc),
    .inc_bin(inc_bin),
    .words  (words)
  );

  always_comb begin
    hctl.rd  = inc || (state == ST_SUM_RD) || (state == ST_EMIT_RD);
    hctl.wr  = pend;
    hctl.clr = finish;
    rd_addr  = (state == ST_IDLE) ? inc_bin : k;
    wr_data  = (&rdata) ? rdata : rdata + COUNT_WIDTH'(1);
  end

  ambrc_hist #(
    .DEPTH (BINS),
    .DATA_W(COUNT_WIDTH)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .ctl    (hctl),
    .rd_addr(rd_addr),
    .wr_addr(pend_bin),
    .wr_data(wr_data),
    .rd_data(rdata)
  );

  ambrc_div #(
    .NUM_W(NUM_W),
    .DEN_W(COUNT_WIDTH),
    .Q_W  (PCT_E_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (analyzed),
    .quot (quot),
    .done (div_done)
  );

  always_comb begin
    k_last    = (k == LVL_W'(MAX_LEVEL));
    km1       = k - LVL_W'(1);
    words_sum = ACC_W'(amb_words) + ACC_W'(rdata);
    total_sum = ACC_W'(amb_total) + ACC_W'(prod);
    words_sat = ((words_sum >> SUM_W) != '0) ? '1 : SUM_W'(words_sum);
    total_sat = ((total_sum >> SUM_W) != '0) ? '1 : SUM_W'(total_sum);
    load      = (state == ST_EMIT_LD) && (!m_axis_tvalid || m_axis_tready);
    finish    = load && k_last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (eos) state_next = ST_SUM_RD;
      ST_SUM_RD:  state_next = ST_SUM_MUL;
      ST_SUM_MUL: state_next = ST_SUM_ADD;
      ST_SUM_ADD: state_next = k_last ? ST_AN : ST_SUM_RD;
      ST_AN:      state_next = ST_LIM;
      ST_LIM:     state_next = ST_CLAMP;
      ST_CLAMP:   state_next = (analyzed != '0) ? ST_NUM_A : ST_EMIT_RD;
      ST_NUM_A:   state_next = ST_DIV_A;
      ST_DIV_A:   if (div_done) state_next = ST_NUM_E;
      ST_NUM_E:   state_next = ST_DIV_E;
      ST_DIV_E:   if (div_done) state_next = ST_EMIT_RD;
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: if (load) state_next = k_last ? ST_IDLE : ST_EMIT_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pend          <= 1'b0;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= inc;
      div_start <= (state == ST_NUM_A) || (state == ST_NUM_E);
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_bin <= inc_bin;
    case (state)
      ST_IDLE: begin
        k         <= '0;
        amb_words <= '0;
        amb_total <= '0;
      end
      ST_SUM_MUL: begin
        if (k == '0) begin
          h0 <= rdata;
        end
        // bins above one add their words and their excess analyses
        if (k >= LVL_W'(2)) begin
          prod      <= PROD_W'(km1) * PROD_W'(rdata);
          amb_words <= words_sat;
        end else begin
          prod <= '0;
        end
      end
      ST_SUM_ADD: begin
        amb_total <= total_sat;
        if (!k_last) begin
          k <= k + LVL_W'(1);
        end
      end
      ST_AN: begin
        analyzed <= (words >= h0) ? words - h0 : '0;
      end
      ST_LIM: begin
        lim    <= PROD_W'(analyzed) * PROD_W'(MAX_LEVEL - 1);
        rvalid <= (analyzed != '0);
        pa     <= '0;
        pe     <= '0;
      end
      ST_CLAMP: begin
        k <= '0;
        if (ACC_W'(amb_words) > ACC_W'(analyzed)) begin
          amb_words <= SUM_W'(analyzed);
        end
        if (ACC_W'(amb_total) > ACC_W'(lim)) begin
          amb_total <= SUM_W'(lim);
        end
      end
      ST_NUM_A: num <= times100(amb_words);
      ST_DIV_A: if (div_done) pa <= quot[PCT_A_W-1:0];
      ST_NUM_E: num <= times100(amb_total);
      ST_DIV_E: if (div_done) pe <= quot;
      ST_EMIT_LD: begin
        if (load) begin
          out_level <= LEVEL_W'(k);
          out_count <= OUT_CNT_W'(rdata);
          out_words <= OUT_CNT_W'(words);
          out_pa    <= pa;
          out_pe    <= pe;
          out_rv    <= rvalid;
          out_last  <= k_last;
          if (!k_last) begin
            k <= k + LVL_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {1'b0, out_pe, out_pa, out_words, out_count, out_level};
  assign m_axis_tuser = out_rv;
  assign m_axis_tlast = out_last;

endmodule
`default_nettype wire

// ===== tb/record_report_checker.sv =====
`timescale 1ns / 1ps
module record_report_checker
  import ambrc_pkg::*;
#(
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  input  wire logic               s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,
  input  wire logic               s_axis_tlast,
  input  wire logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  input  wire logic [TDATA_W-1:0] m_axis_tdata,
  input  wire logic               m_axis_tuser,
  input  wire logic               m_axis_tlast,
  output int                      errors,
  output int                      pending
);

  localparam int BINS    = MAX_LEVEL + 1;
  localparam int CNT_LSB = LEVEL_W;
  localparam int WRD_LSB = CNT_LSB + OUT_CNT_W;
  localparam int PA_LSB  = WRD_LSB + OUT_CNT_W;
  localparam int PE_LSB  = PA_LSB + PCT_A_W;
  localparam int PAD_LSB = PE_LSB + PCT_E_W;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_BSLASH,
    SCAN_SKIP,
    SCAN_PERCENT,
    SCAN_DIGITS,
    SCAN_DUMMY
  } scan_phase_t;

  typedef struct {
    logic [LEVEL_W-1:0]   level;
    logic [OUT_CNT_W-1:0] level_count;
    logic [OUT_CNT_W-1:0] word_count;
    logic [PCT_A_W-1:0]   pct_ambiguous;
    logic [PCT_E_W-1:0]   pct_excess;
    logic                 ratios_valid;
    logic                 last_bin;
  } bin_report_t;

  scan_phase_t            phase;
  int unsigned            level_acc;
  logic [COUNT_WIDTH-1:0] words;
  logic [COUNT_WIDTH-1:0] hist [BINS];
  logic                   halted;
  bin_report_t            expected_bins [$];

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic clear_counts();
    phase     = SCAN_IDLE;
    level_acc = 0;
    words     = '0;
    halted    = 1'b0;
    foreach (hist[k]) hist[k] = '0;
  endtask

  task automatic bump_bin(input int unsigned lv);
    if (lv > MAX_LEVEL) lv = MAX_LEVEL;
    hist[lv] = sat_inc(hist[lv]);
  endtask

  task automatic parse_text_byte(input logic [7:0] c);
    int unsigned nxt;
    case (phase)
      SCAN_IDLE: begin
        if (c == CH_NUL) halted = 1'b1;
        else if (c == CH_BSLASH) phase = SCAN_BSLASH;
      end
      SCAN_BSLASH: begin
        if (c == CH_A) begin
          words = sat_inc(words);
          phase = SCAN_SKIP;
        end else begin
          phase = SCAN_IDLE;
        end
      end
      SCAN_SKIP: phase = SCAN_PERCENT;
      SCAN_PERCENT: begin
        if (c == CH_PCT) begin
          level_acc = 0;
          phase     = SCAN_DIGITS;
        end else begin
          bump_bin(1);
          phase = SCAN_IDLE;
        end
      end
      SCAN_DIGITS: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          nxt       = level_acc * 10 + int'(c - CH_ZERO);
          level_acc = (nxt > MAX_LEVEL) ? MAX_LEVEL : nxt;
        end else if (level_acc == 0) begin
          phase = SCAN_DUMMY;
        end else begin
          bump_bin(level_acc);
          phase = SCAN_IDLE;
        end
      end
      SCAN_DUMMY: begin
        // a '%' here marks a dummy record: take the word back
        if (c == CH_PCT) begin
          if (words != 0) words = words - 1'b1;
        end else begin
          bump_bin(0);
        end
        phase = SCAN_IDLE;
      end
      default: phase = SCAN_IDLE;
    endcase
  endtask

  task automatic issue_report();
    logic [SUM_W-1:0] analyzed;
    logic [SUM_W-1:0] amb_words;
    logic [SUM_W-1:0] amb_total;
    logic [SUM_W-1:0] pa;
    logic [SUM_W-1:0] pe;
    logic             valid;
    bin_report_t      r;
    analyzed  = (words >= hist[0]) ? SUM_W'(words) - SUM_W'(hist[0]) : '0;
    amb_words = '0;
    amb_total = '0;
    for (int k = 2; k < BINS; k++) begin
      amb_words = amb_words + SUM_W'(hist[k]);
      amb_total = amb_total + SUM_W'(k - 1) * SUM_W'(hist[k]);
    end
    valid = (analyzed != 0);
    pa    = '0;
    pe    = '0;
    if (valid) begin
      if (amb_words > analyzed) amb_words = analyzed;
      if (amb_total > analyzed * SUM_W'(MAX_LEVEL - 1))
        amb_total = analyzed * SUM_W'(MAX_LEVEL - 1);
      pa = (amb_words * 100) / analyzed;
      pe = (amb_total * 100) / analyzed;
    end
    for (int k = 0; k < BINS; k++) begin
      r.level         = LEVEL_W'(k);
      r.level_count   = OUT_CNT_W'(hist[k]);
      r.word_count    = OUT_CNT_W'(words);
      r.pct_ambiguous = pa[PCT_A_W-1:0];
      r.pct_excess    = pe[PCT_E_W-1:0];
      r.ratios_valid  = valid;
      r.last_bin      = (k == MAX_LEVEL);
      expected_bins.push_back(r);
    end
    clear_counts();
  endtask

  task automatic compare_field(input string what, input logic [4:0] bin,
                               input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: bin %0d %s mismatch, expected %0d, actual %0d",
               $time, bin, what, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    bin_report_t want;
    if (expected_bins.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
               $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      errors++;
    end else begin
      want = expected_bins.pop_front();
      compare_field("level", want.level, 32'(want.level),
                    32'(m_axis_tdata[LEVEL_W-1:0]));
      compare_field("level_count", want.level, want.level_count,
                    m_axis_tdata[CNT_LSB +: OUT_CNT_W]);
      compare_field("word_count", want.level, want.word_count,
                    m_axis_tdata[WRD_LSB +: OUT_CNT_W]);
      compare_field("pct_ambiguous", want.level, 32'(want.pct_ambiguous),
                    32'(m_axis_tdata[PA_LSB +: PCT_A_W]));
      compare_field("pct_excess", want.level, 32'(want.pct_excess),
                    32'(m_axis_tdata[PE_LSB +: PCT_E_W]));
      compare_field("tdata padding", want.level, 32'd0,
                    32'(m_axis_tdata[TDATA_W-1:PAD_LSB]));
      compare_field("ratios_valid", want.level, 32'(want.ratios_valid),
                    32'(m_axis_tuser));
      compare_field("last_bin", want.level, 32'(want.last_bin), 32'(m_axis_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_counts();
      expected_bins.delete();
      errors = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tlast) issue_report();
        else if (!halted) parse_text_byte(s_axis_tdata);
      end
    end
    pending = expected_bins.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ambrc_pkg::*;

  localparam int HOLD_CYCLES = 400;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = 8'd0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  int errors;
  int pending;
  int snd_idle    = 38;
  int rcv_idle    = 46;
  int holds_asked = 0;
  int holds_done  = 0;
  int sent        = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ambiguity_record_counter uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  record_report_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .pending       (pending)
  );

  // receiver: random stalls, or a long hold when one is asked for
  initial begin
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic offer(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer(b, 1'b0);
    sent++;
  endtask

  task automatic send_eos();
    offer(8'($urandom_range(255)), 1'b1);
    sent++;
  endtask

  task automatic send_non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b >= CH_ZERO && b <= CH_NINE);
    send_byte(b);
  endtask

  task automatic send_record();
    int unsigned form;
    int unsigned ndig;
    logic [7:0]  b;
    send_byte(CH_BSLASH);
    send_byte(CH_A);
    send_byte(8'($urandom_range(255)));
    form = $urandom_range(9);
    if (form < 2) begin
      do b = 8'($urandom_range(255)); while (b == CH_PCT);
      send_byte(b);
    end else begin
      send_byte(CH_PCT);
      ndig = $urandom_range(3);
      repeat (ndig) send_byte((form < 5) ? CH_ZERO : CH_ZERO + 8'($urandom_range(9)));
      send_non_digit();
      // level zero: follow with '%' for a dummy record or anything else
      if (form < 5) send_byte($urandom_range(1) ? CH_PCT : 8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int n);
    int stop;
    int unsigned pick;
    stop = sent + n;
    while (sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_record();
      end else if (pick < 76) begin
        send_byte(CH_BSLASH);
        send_byte(8'($urandom_range(255)));
      end else if (pick < 80) begin
        send_eos();
      end else begin
        send_byte(($urandom_range(39) == 0) ? CH_NUL : 8'($urandom_range(1, 255)));
      end
    end
    send_eos();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty report: no analysed words
    send_eos();
    // zero as skipped byte, clamped level, 0xFF as terminator
    send_byte(CH_BSLASH); send_byte(CH_A); send_byte(CH_NUL); send_byte(CH_PCT);
    send_byte(CH_NINE); send_byte(CH_NINE); send_byte(8'hFF);
    // dummy record
    send_byte(CH_BSLASH); send_byte(CH_A); send_byte(8'h78); send_byte(CH_PCT);
    send_byte(CH_ZERO); send_byte(8'h3B); send_byte(CH_PCT);
    // backslash without 'a'
    send_byte(CH_BSLASH); send_byte(8'h71);
    // report in the middle of a record
    send_byte(CH_BSLASH); send_byte(CH_A); send_byte(8'h78); send_byte(CH_PCT);
    send_eos();
    // zero byte while idle halts the parser
    send_byte(CH_NUL); send_byte(CH_BSLASH); send_byte(CH_A);
    send_eos();

    run_random(20);

    snd_idle = 46;
    rcv_idle = 38;
    run_random(20);

    snd_idle = 0;
    rcv_idle = 0;
    holds_asked++;
    run_random(8);
    run_random(12);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ambrc_pkg.sv
hdl/ambrc_hist.sv
hdl/ambrc_div.sv
hdl/ambrc_parse.sv
hdl/ambiguity_record_counter.sv
tb/record_report_checker.sv
tb/tb.sv
